// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal held stable while a condition holds.
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== hdl/hsd_pkg.sv =====
`default_nettype none
package hsd_pkg;

  localparam int MaxNodes   = 512;
  localparam int StackDepth = 256;

  localparam logic [7:0] InternalMark = 8'h2A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       run_last;
    logic       stream_done;
    logic       format_error;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // take input word into the byte registers
    logic hdr0;        // process header byte 0
    logic hdr1;        // process header byte 1
    logic tree_rd;     // read the parent node of a tree byte
    logic tree_wr;     // write the new node and update the tree state
    logic tree_par;    // write back the updated parent node
    logic data_start;  // start bit walk of a data byte
    logic walk_rd;     // read the current walk node
    logic walk_nxt;    // read the child selected by the current bit
    logic walk_step;   // take the bit step, may emit
    logic clear;       // end of file reset of state
  } hsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] phase;
    logic       error;
    logic       final_byte;
    logic       bits_done;
    logic       emit;
  } hsd_stat_t;

  localparam logic [1:0] PhHdr0 = 2'd0;
  localparam logic [1:0] PhHdr1 = 2'd1;
  localparam logic [1:0] PhTree = 2'd2;
  localparam logic [1:0] PhData = 2'd3;

endpackage
`default_nettype wire

// ===== hdl/hsd_datapath.sv =====
`default_nettype none
module hsd_datapath #(
  parameter int MaxNodes   = hsd_pkg::MaxNodes,
  parameter int StackDepth = hsd_pkg::StackDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hsd_pkg::in_word_t in_word_i,
  input  wire hsd_pkg::hsd_cmd_t cmd_i,
  output hsd_pkg::hsd_stat_t     stat_o,
  output hsd_pkg::out_word_t     emit_word_o
);

  localparam int NW = $clog2(MaxNodes);
  localparam int CW = $clog2(MaxNodes + 1);
  localparam int SW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int TW = $clog2(StackDepth + 1);

  // Node entry: internal flag, symbol, left, right, left-set flag.
  typedef struct packed {
    logic          internal;
    logic [7:0]    symbol;
    logic [NW-1:0] left;
    logic [NW-1:0] right;
    logic          has_left;
  } node_t;

  node_t         node_mem [MaxNodes];
  logic [NW-1:0] stack_mem [StackDepth];

  logic [1:0]    phase_q, phase_d;
  logic [2:0]    pad_q, pad_d;
  logic [12:0]   left_q, left_d;
  logic [CW-1:0] count_q, count_d;
  logic [TW-1:0] top_q, top_d;
  logic [NW-1:0] walk_q, walk_d;
  logic          err_q, err_d;
  logic [7:0]    byte_q;
  logic          fin_q;
  logic [3:0]    bit_q, bit_d;
  logic [3:0]    nbits_q, nbits_d;
  logic          root_leaf_q, root_leaf_d;
  logic [7:0]    root_sym_q, root_sym_d;

  // Registered reads: stacked parent and node table.
  logic [NW-1:0] par_q;
  logic [NW-1:0] rd_addr;
  logic          rd_en;
  node_t         rd_q;
  logic [NW-1:0] nxt_q;

  // Parent update waiting for its write slot.
  node_t         pend_q;
  logic [NW-1:0] pend_addr_q;
  logic          pend_v_q;

  logic          complete;
  logic          is_int;
  logic          has_parent;
  logic          cur_bit;
  logic [NW-1:0] nxt;
  logic          add_en;
  node_t         new_node;
  node_t         par_data;
  logic          pop;
  logic [TW-1:0] push_slot;
  logic          push_en;

  assign complete   = (count_q != '0) && (top_q == '0);
  assign is_int     = (byte_q == hsd_pkg::InternalMark);
  assign has_parent = (count_q != '0);
  assign cur_bit    = byte_q[3'd7 - bit_q[2:0]];
  assign nxt        = cur_bit ? rd_q.right : rd_q.left;

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_word_i.in_byte;
      fin_q  <= in_word_i.final_byte;
    end
  end

  // Parent index from the top of the stack, registered ahead of its use.
  always_ff @(posedge clk_i) begin
    par_q <= stack_mem[SW'(top_q - TW'(1))];
  end

  // Node table read port: parent for tree bytes, walk node and child for data.
  always_comb begin
    rd_addr = walk_q;
    if (cmd_i.tree_rd) rd_addr = par_q;
    else if (cmd_i.walk_nxt) rd_addr = nxt;
  end

  assign rd_en = cmd_i.tree_rd | cmd_i.walk_rd | cmd_i.walk_nxt;

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= node_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_nxt) nxt_q <= nxt;
  end

  // New node, parent update and stack push of one tree byte.
  assign add_en   = cmd_i.tree_wr && !err_q && !complete && (count_q < CW'(MaxNodes));
  assign new_node = '{internal: is_int, symbol: byte_q, left: '0, right: '0, has_left: 1'b0};

  always_comb begin
    par_data = rd_q;
    pop      = 1'b0;
    if (!rd_q.has_left) begin
      par_data.left     = count_q[NW-1:0];
      par_data.has_left = 1'b1;
    end else begin
      par_data.right = count_q[NW-1:0];
      pop            = 1'b1;
    end
  end

  assign push_slot = (has_parent && pop) ? top_q - TW'(1) : top_q;
  assign push_en   = add_en && is_int && (push_slot < TW'(StackDepth));

  // The new node is written first, the parent in the following cycle.
  always_ff @(posedge clk_i) begin
    if (add_en) node_mem[count_q[NW-1:0]] <= new_node;
    else if (cmd_i.tree_par && pend_v_q) node_mem[pend_addr_q] <= pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.tree_wr) begin
      pend_v_q <= add_en && has_parent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tree_wr) begin
      pend_q      <= par_data;
      pend_addr_q <= par_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) stack_mem[SW'(push_slot)] <= count_q[NW-1:0];
  end

  // State update.
  always_comb begin
    phase_d     = phase_q;
    pad_d       = pad_q;
    left_d      = left_q;
    count_d     = count_q;
    top_d       = top_q;
    walk_d      = walk_q;
    err_d       = err_q;
    bit_d       = bit_q;
    nbits_d     = nbits_q;
    root_leaf_d = root_leaf_q;
    root_sym_d  = root_sym_q;
    if (cmd_i.hdr0) begin
      pad_d   = byte_q[7:5];
      left_d  = {byte_q[4:0], 8'h00};
      phase_d = hsd_pkg::PhHdr1;
    end
    if (cmd_i.hdr1) begin
      left_d = left_q | {5'd0, byte_q};
      if ((left_q | {5'd0, byte_q}) == 13'd0) begin
        err_d   = 1'b1;
        phase_d = hsd_pkg::PhData;
      end else begin
        phase_d = hsd_pkg::PhTree;
      end
    end
    if (cmd_i.tree_wr) begin
      if (!err_q && !complete) begin
        if (count_q >= CW'(MaxNodes)) begin
          err_d = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
          if (!has_parent) begin
            root_leaf_d = !is_int;
            root_sym_d  = byte_q;
          end
          top_d = push_slot;
          if (is_int) begin
            if (push_slot >= TW'(StackDepth)) err_d = 1'b1;
            else top_d = push_slot + TW'(1);
          end
        end
      end
      left_d = left_q - 13'd1;
      if (left_q == 13'd1) begin
        phase_d = hsd_pkg::PhData;
        if (!((count_d != '0) && (top_d == '0))) err_d = 1'b1;
      end
    end
    if (cmd_i.data_start) begin
      bit_d   = 4'd0;
      nbits_d = fin_q ? (4'd8 - {1'b0, pad_q}) : 4'd8;
    end
    if (cmd_i.walk_step) begin
      bit_d = bit_q + 4'd1;
      if (!root_leaf_q) walk_d = rd_q.internal ? nxt_q : '0;
    end
    if (cmd_i.clear) begin
      phase_d = hsd_pkg::PhHdr0;
      pad_d   = '0;
      left_d  = '0;
      count_d = '0;
      top_d   = '0;
      walk_d  = '0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hsd_pkg::PhHdr0;
      pad_q       <= '0;
      left_q      <= '0;
      count_q     <= '0;
      top_q       <= '0;
      walk_q      <= '0;
      err_q       <= 1'b0;
      bit_q       <= '0;
      nbits_q     <= '0;
      root_leaf_q <= 1'b0;
      root_sym_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      pad_q       <= pad_d;
      left_q      <= left_d;
      count_q     <= count_d;
      top_q       <= top_d;
      walk_q      <= walk_d;
      err_q       <= err_d;
      bit_q       <= bit_d;
      nbits_q     <= nbits_d;
      root_leaf_q <= root_leaf_d;
      root_sym_q  <= root_sym_d;
    end
  end

  // Symbol of the pending bit step and status.
  assign emit_word_o = '{out_symbol: root_leaf_q ? root_sym_q : rd_q.symbol,
                         run_last: 1'b0, stream_done: 1'b0, format_error: 1'b0};

  assign stat_o.phase      = phase_q;
  assign stat_o.error      = err_q;
  assign stat_o.final_byte = fin_q;
  assign stat_o.bits_done  = (bit_q >= nbits_q);
  assign stat_o.emit       = root_leaf_q | ~rd_q.internal;

endmodule
`default_nettype wire

// ===== hdl/hsd_controller.sv =====
`default_nettype none
module hsd_controller (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output hsd_pkg::hsd_cmd_t       cmd_o,
  input  wire hsd_pkg::hsd_stat_t stat_i,
  input  wire hsd_pkg::out_word_t emit_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hsd_pkg::out_word_t      out_word_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StTreeB = 4'd2;
  localparam logic [3:0] StTreeC = 4'd3;
  localparam logic [3:0] StFlag  = 4'd4;
  localparam logic [3:0] StWalkA = 4'd5;
  localparam logic [3:0] StWalkB = 4'd6;
  localparam logic [3:0] StWalkC = 4'd7;
  localparam logic [3:0] StEnd   = 4'd8;

  logic [3:0] state_q, state_d;

  // One held symbol waits for the next emission or end of byte, so the
  // last one of a byte can be marked.
  logic               hold_v_q, hold_v_d;
  hsd_pkg::out_word_t hold_q, hold_d;
  logic               ov_q, ov_d;
  hsd_pkg::out_word_t ow_q, ow_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

  always_comb begin
    state_d  = state_q;
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    ov_d     = ov_q;
    ow_d     = ow_q;
    cmd_o    = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StDec;
        end
      end
      StDec: begin
        priority if (stat_i.phase == hsd_pkg::PhHdr0) begin
          cmd_o.hdr0 = 1'b1;
          state_d    = StFlag;
        end else if (stat_i.phase == hsd_pkg::PhHdr1) begin
          cmd_o.hdr1 = 1'b1;
          state_d    = StFlag;
        end else if (stat_i.phase == hsd_pkg::PhTree) begin
          cmd_o.tree_rd = 1'b1;
          state_d       = StTreeB;
        end else if (stat_i.error) begin
          if (!ov_d) begin
            ov_d  = 1'b1;
            ow_d  = '{out_symbol: 8'd0, run_last: 1'b1,
                      stream_done: stat_i.final_byte, format_error: 1'b1};
            cmd_o.clear = stat_i.final_byte;
            state_d     = StIdle;
          end
        end else begin
          cmd_o.data_start = 1'b1;
          state_d          = StWalkA;
        end
      end
      StTreeB: begin
        cmd_o.tree_wr = 1'b1;
        state_d       = StTreeC;
      end
      StTreeC: begin
        cmd_o.tree_par = 1'b1;
        state_d        = StFlag;
      end
      StFlag: begin
        // Header or tree byte done: a final byte here truncates the file.
        if (!stat_i.final_byte) begin
          state_d = StIdle;
        end else if (!ov_d) begin
          ov_d        = 1'b1;
          ow_d        = '{out_symbol: 8'd0, run_last: 1'b1, stream_done: 1'b1,
                          format_error: 1'b1};
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end
      end
      StWalkA: begin
        if (stat_i.bits_done) begin
          state_d = StEnd;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = StWalkB;
        end
      end
      StWalkB: begin
        cmd_o.walk_nxt = 1'b1;
        state_d        = StWalkC;
      end
      StWalkC: begin
        // Take the bit step once any symbol it emits has somewhere to go.
        if (!stat_i.emit) begin
          cmd_o.walk_step = 1'b1;
          state_d         = StWalkA;
        end else if (!hold_v_q) begin
          hold_v_d        = 1'b1;
          hold_d          = emit_word_i;
          cmd_o.walk_step = 1'b1;
          state_d         = StWalkA;
        end else if (!ov_d) begin
          ov_d            = 1'b1;
          ow_d            = hold_q;
          hold_d          = emit_word_i;
          cmd_o.walk_step = 1'b1;
          state_d         = StWalkA;
        end
      end
      StEnd: begin
        // Byte finished: flush the held symbol as the last of the byte.
        if (!hold_v_q) begin
          cmd_o.clear = stat_i.final_byte;
          state_d     = StIdle;
        end else if (!ov_d) begin
          ov_d             = 1'b1;
          ow_d             = hold_q;
          ow_d.run_last    = 1'b1;
          ow_d.stream_done = stat_i.final_byte;
          hold_v_d         = 1'b0;
          cmd_o.clear      = stat_i.final_byte;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      hold_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    ow_q   <= ow_d;
  end

endmodule
`default_nettype wire

// ===== hdl/huffman_stream_decoder_unit.sv =====
// Huffman stream decoder.
// Input channel: one compressed-file word (byte plus final flag) per
// handshake on in_valid_i / in_ready_o. Header bytes, then the preorder
// tree bytes, then data bytes.
// Output channel: decoded symbol words on out_valid_o / out_ready_i, each
// with run_last (last of its input byte), stream_done and format_error.
// A tree byte is handled as a parent node read, a new node write and a
// parent write back. Each bit of a data byte needs two dependent node
// table reads, the walk node and then its child, before its bit step.
// A data byte after a format error yields one error word and no walk.
// The block takes one input word at a time; in_ready_o is high only while
// no word is in progress.
// A symbol is held until the next one is found or its byte ends, so that
// run_last can be set; it then moves into the single output register.
// When the receiver stalls, that register holds its word and decoding
// pauses at the next symbol that needs the register.
// Reset clears all control state; the node table and parent stack are
// never cleared, as entries are always written before their contents are used.
// A final byte clears header, tree, walk and error state for a new file.
`default_nettype none
module huffman_stream_decoder_unit #(
  parameter int MaxNodes   = hsd_pkg::MaxNodes,
  parameter int StackDepth = hsd_pkg::StackDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hsd_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hsd_pkg::out_word_t      out_word_o
);

  hsd_pkg::hsd_cmd_t  cmd;
  hsd_pkg::hsd_stat_t stat;
  hsd_pkg::out_word_t emit_word;

  hsd_datapath #(
    .MaxNodes  (MaxNodes),
    .StackDepth(StackDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .emit_word_o(emit_word)
  );

  hsd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat),
    .emit_word_i(emit_word),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire

// ===== hdl/hsd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module hsd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire hsd_pkg::out_word_t out_word_o
);

  // A stalled output word holds.
  `ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_word_o, "out word changed")

  // A done word is always the last of its byte.
  `ASSERT_IMPL(a_done_last, clk_i, rst_ni, !out_valid_o || !out_word_o.stream_done || out_word_o.run_last, "done without last")

  // An error word carries symbol zero and ends its byte.
  `ASSERT_IMPL(a_err_word, clk_i, rst_ni, !(out_valid_o && out_word_o.format_error) || (out_word_o.out_symbol == 8'd0 && out_word_o.run_last), "bad error word")

  // An accepted word drops ready for the next cycle.
  `ASSERT_IMPL(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready held after accept")

endmodule

bind huffman_stream_decoder_unit hsd_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;

  localparam int CycleLimit = 200000;
  localparam int MaxNodes   = 32;
  localparam int StackDepth = 16;

  // Node record of the expected decoding tree.
  typedef struct {
    bit         is_inner;
    logic [7:0] sym;
    int         lchild;
    int         rchild;
    bit         has_l;
  } tree_node_t;

  // One row of the directed table; a pinned row carries its own expected word.
  typedef struct {
    logic [7:0]         b;
    bit                 fin;
    bit                 pinned;
    hsd_pkg::out_word_t w;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  hsd_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  hsd_pkg::out_word_t out_word_o;

  huffman_stream_decoder_unit #(
    .MaxNodes  (MaxNodes),
    .StackDepth(StackDepth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Decoder state as the testbench expects it.
  logic [1:0]  ph;
  logic [2:0]  pad;
  int          tree_left;
  tree_node_t  nodes [MaxNodes];
  int          n_nodes;
  int          parents [StackDepth];
  int          depth;
  int          cursor;
  bit          bad_tree;

  hsd_pkg::out_word_t symbols_due [$];
  hsd_pkg::out_word_t step_syms [$];
  logic [7:0]  file_bytes [$];
  row_t        rows [$];
  int          mismatches;
  int          cycles;
  int          rx_hold;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_decoder();
    ph = hsd_pkg::PhHdr0;
    pad = '0;
    tree_left = 0;
    n_nodes = 0;
    depth = 0;
    cursor = 0;
    bad_tree = 1'b0;
  endfunction

  function automatic bit tree_done();
    return n_nodes > 0 && depth == 0;
  endfunction

  // Preorder insertion of one tree byte using the parent stack.
  function automatic void insert_node(logic [7:0] b);
    int n;
    int p;
    if (n_nodes >= MaxNodes) begin
      bad_tree = 1'b1;
      return;
    end
    n = n_nodes;
    n_nodes++;
    nodes[n].is_inner = (b == hsd_pkg::InternalMark);
    nodes[n].sym = b;
    nodes[n].lchild = 0;
    nodes[n].rchild = 0;
    nodes[n].has_l = 1'b0;
    if (n > 0) begin
      if (depth == 0 || depth > StackDepth) begin
        bad_tree = 1'b1;
        return;
      end
      p = parents[depth-1];
      if (!nodes[p].has_l) begin
        nodes[p].lchild = n;
        nodes[p].has_l = 1'b1;
      end else begin
        nodes[p].rchild = n;
        depth--;
      end
    end
    if (nodes[n].is_inner) begin
      if (depth >= StackDepth) begin
        bad_tree = 1'b1;
        return;
      end
      parents[depth] = n;
      depth++;
    end
  endfunction

  function automatic hsd_pkg::out_word_t mk(logic [7:0] s, bit l, bit d, bit e);
    hsd_pkg::out_word_t w;
    w.out_symbol = s;
    w.run_last = l;
    w.stream_done = d;
    w.format_error = e;
    return w;
  endfunction

  // Symbols decoded from one input word, left in step_syms.
  function automatic void decode_word(hsd_pkg::in_word_t w);
    int nbits;
    int nxt;
    bit bitv;
    step_syms.delete();
    if (ph != hsd_pkg::PhData) begin
      if (ph == hsd_pkg::PhHdr0) begin
        pad = w.in_byte[7:5];
        tree_left = int'(w.in_byte[4:0]) << 8;
        ph = hsd_pkg::PhHdr1;
      end else if (ph == hsd_pkg::PhHdr1) begin
        tree_left = tree_left | int'(w.in_byte);
        if (tree_left == 0) begin
          bad_tree = 1'b1;
          ph = hsd_pkg::PhData;
        end else begin
          ph = hsd_pkg::PhTree;
        end
      end else begin
        if (!bad_tree && !tree_done()) insert_node(w.in_byte);
        tree_left--;
        if (tree_left == 0) begin
          if (!tree_done()) bad_tree = 1'b1;
          ph = hsd_pkg::PhData;
        end
      end
      if (w.final_byte) begin
        step_syms.push_back(mk(8'h00, 1'b1, 1'b1, 1'b1));
        clear_decoder();
      end
      return;
    end
    if (bad_tree) begin
      step_syms.push_back(mk(8'h00, 1'b1, w.final_byte, 1'b1));
      if (w.final_byte) clear_decoder();
      return;
    end
    nbits = w.final_byte ? 8 - int'(pad) : 8;
    for (int k = 0; k < nbits; k++) begin
      bitv = w.in_byte[7-k];
      if (!nodes[0].is_inner) begin
        step_syms.push_back(mk(nodes[0].sym, 1'b0, 1'b0, 1'b0));
      end else begin
        nxt = bitv ? nodes[cursor].rchild : nodes[cursor].lchild;
        if (nodes[nxt].is_inner) begin
          cursor = nxt;
        end else begin
          step_syms.push_back(mk(nodes[nxt].sym, 1'b0, 1'b0, 1'b0));
          cursor = 0;
        end
      end
    end
    if (step_syms.size() > 0) begin
      step_syms[$].run_last = 1'b1;
      step_syms[$].stream_done = w.final_byte;
    end
    if (w.final_byte) clear_decoder();
  endfunction

  // Drive one word, wait for acceptance, then queue its expected symbols.
  task automatic send_word(logic [7:0] b, bit fin, bit pinned, hsd_pkg::out_word_t pw);
    hsd_pkg::in_word_t w;
    w.in_byte = b;
    w.final_byte = fin;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    decode_word(w);
    if (pinned) symbols_due.push_back(pw);
    else foreach (step_syms[i]) symbols_due.push_back(step_syms[i]);
  endtask

  task automatic send_plain(logic [7:0] b, bit fin);
    send_word(b, fin, 1'b0, '0);
  endtask

  task automatic add_row(logic [7:0] b, bit fin);
    row_t r;
    r.b = b;
    r.fin = fin;
    r.pinned = 1'b0;
    r.w = '0;
    rows.push_back(r);
  endtask

  task automatic add_pinned(logic [7:0] b, bit fin, hsd_pkg::out_word_t w);
    row_t r;
    r.b = b;
    r.fin = fin;
    r.pinned = 1'b1;
    r.w = w;
    rows.push_back(r);
  endtask

  function automatic logic [7:0] leaf_sym();
    logic [7:0] s;
    do s = 8'($urandom_range(0, 255)); while (s == hsd_pkg::InternalMark);
    return s;
  endfunction

  // Random full binary tree in preorder, appended to file_bytes.
  function automatic void grow_tree(int leaves);
    int l;
    if (leaves <= 1) begin
      file_bytes.push_back(leaf_sym());
      return;
    end
    file_bytes.push_back(hsd_pkg::InternalMark);
    l = $urandom_range(1, leaves - 1);
    grow_tree(l);
    grow_tree(leaves - l);
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Sends file_bytes as header byte 0, header byte 1, then the body.
  task automatic send_file(logic [2:0] p, int size);
    logic [12:0] sz;
    sz = 13'(size);
    send_plain({p, sz[12:8]}, 1'b0);
    send_plain(sz[7:0], 1'b0);
    foreach (file_bytes[i]) send_plain(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Receiver with random stall bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      rx_hold <= $urandom_range(0, 11);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted symbol word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (symbols_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_word_o);
      end else begin
        if (out_word_o.out_symbol !== symbols_due[0].out_symbol ||
            out_word_o.run_last !== symbols_due[0].run_last ||
            out_word_o.stream_done !== symbols_due[0].stream_done ||
            out_word_o.format_error !== symbols_due[0].format_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", symbols_due[0], out_word_o);
        end
        void'(symbols_due.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int sent;
    int kind;
    int leaves;
    int extra;
    int ndata;
    logic [2:0] p;
    in_valid_i = 1'b0;
    in_word_i = '0;
    rst_ni = 1'b0;
    mismatches = 0;
    cycles = 0;
    quiet = 1'b0;
    clear_decoder();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Truncated file in the header.
    add_pinned(8'h00, 1'b1, mk(8'h00, 1'b1, 1'b1, 1'b1));
    // Empty tree: every data word reports the format error.
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_pinned(8'hFF, 1'b0, mk(8'h00, 1'b1, 1'b0, 1'b1));
    add_pinned(8'h00, 1'b1, mk(8'h00, 1'b1, 1'b1, 1'b1));
    // Single leaf, three pad bits.
    add_row(8'h60, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hA5, 1'b0);
    add_row(8'h00, 1'b1);
    // Three-node tree with two surplus tree bytes and seven pad bits.
    add_row(8'hE0, 1'b0);
    add_row(8'h05, 1'b0);
    add_row(hsd_pkg::InternalMark, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h11, 1'b0);
    add_row(hsd_pkg::InternalMark, 1'b0);
    add_row(8'h5A, 1'b0);
    add_row(8'hFF, 1'b1);
    // Incomplete tree, then a final data word.
    add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(hsd_pkg::InternalMark, 1'b0);
    add_row(8'h41, 1'b0);
    add_pinned(8'h3C, 1'b1, mk(8'h00, 1'b1, 1'b1, 1'b1));
    // Truncated file in the tree.
    add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_pinned(hsd_pkg::InternalMark, 1'b1, mk(8'h00, 1'b1, 1'b1, 1'b1));
    foreach (rows[i]) send_word(rows[i].b, rows[i].fin, rows[i].pinned, rows[i].w);

    // Stack overflow: a run of internal nodes deeper than the stack.
    file_bytes.delete();
    repeat (StackDepth + 4) file_bytes.push_back(hsd_pkg::InternalMark);
    file_bytes.push_back(8'h77);
    send_file(3'd2, StackDepth + 5);
    // Node table full: the stack stays at two while the table fills.
    file_bytes.delete();
    file_bytes.push_back(hsd_pkg::InternalMark);
    repeat (MaxNodes / 2 + 1) begin
      file_bytes.push_back(hsd_pkg::InternalMark);
      file_bytes.push_back(8'h61);
    end
    file_bytes.push_back(8'h9C);
    send_file(3'd0, file_bytes.size());

    // Sender holds off until every expected word is back.
    wait_drained();

    // Random files, mostly well formed.
    sent = 0;
    while (sent < 80) begin
      if (sent > 60) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      file_bytes.delete();
      p = 3'($urandom_range(0, 7));
      if (kind < 8) begin
        leaves = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
        grow_tree(leaves);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (extra) file_bytes.push_back(8'($urandom_range(0, 255)));
        extra = file_bytes.size();
        ndata = $urandom_range(1, 6);
        repeat (ndata) file_bytes.push_back(8'($urandom_range(0, 255)));
        send_file(p, extra);
        sent += extra + ndata + 2;
      end else if (kind == 8) begin
        // Broken file: ends inside the tree.
        grow_tree($urandom_range(3, 8));
        extra = file_bytes.size();
        file_bytes = file_bytes[0:$urandom_range(0, extra - 2)];
        send_file(p, extra);
        sent += file_bytes.size() + 2;
      end else begin
        // Noise bytes ending in a final word.
        ndata = $urandom_range(1, 6);
        repeat (ndata) file_bytes.push_back(8'($urandom_range(0, 255)));
        foreach (file_bytes[i]) send_plain(file_bytes[i], i == ndata - 1);
        sent += ndata;
      end
    end
    in_valid_i <= 1'b0;

    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/hsd_pkg.sv
hdl/hsd_datapath.sv
hdl/hsd_controller.sv
hdl/huffman_stream_decoder_unit.sv
hdl/hsd_checker.sv
dv/tb_top.sv
